[rtl/core/charger_blink_fault_detector_top_defines.svh]
// assertion macros for the charger blink fault detector
// expects signals named clock and reset in the module that uses them
`ifndef CHARGER_BLINK_FAULT_DETECTOR_TOP_DEFINES_SVH
`define CHARGER_BLINK_FAULT_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CBFD_ASSERT_NOW(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define CBFD_ASSERT_NEXT(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

[rtl/core/cbfd_pkg.sv]
// shared types and constants of the charger blink fault detector
// no dependencies
`default_nettype none

package cbfd_pkg;

   // item kinds on the request side
   localparam logic CMD_EDGE  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register indexes
   localparam logic [1:0] REG_MIN_PERIOD = 2'd0;
   localparam logic [1:0] REG_MAX_PERIOD = 2'd1;
   localparam logic [1:0] REG_COUNT      = 2'd2;
   localparam logic [1:0] REG_HOLD       = 2'd3;

   // register reset values
   localparam logic [15:0] MIN_PERIOD_RESET = 16'd400;
   localparam logic [15:0] MAX_PERIOD_RESET = 16'd2000;
   localparam logic [7:0]  COUNT_RESET      = 8'd3;
   localparam logic [15:0] HOLD_RESET       = 16'd3000;

   // reported power modes
   localparam logic [1:0] MODE_OFF         = 2'd0;
   localparam logic [1:0] MODE_WIRE_FAULT  = 2'd1;
   localparam logic [1:0] MODE_WIRELESS_ON = 2'd2;
   localparam logic [1:0] MODE_WIRE_ON     = 2'd3;

   typedef enum logic [1:0] {
      WIRE_OFF   = 2'd0,
      WIRE_ON    = 2'd1,
      WIRE_FAULT = 2'd2
   } wire_status_type;

   typedef struct packed {
      logic [15:0] min_period_ms;
      logic [15:0] max_period_ms;
      logic [7:0]  count_needed;
      logic [15:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      logic        cmd;
      logic [31:0] now_ms;
      logic        wire_pin_level;
      logic        wireless_pin_level;
   } item_type;

   typedef struct packed {
      logic [1:0] power_mode;
      logic [1:0] wire_state;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/charger_blink_fault_detector_top.sv]
// a query item goes from the input register into the result register, which drives rsp
// throughput: one item per cycle while no query is held; an edge item gives no result
// and leaves the input register in the cycle after it is taken
// a query waits in the input register only while the result register is held
// reset (synchronous, active high) empties both registers, clears the blink
// state to wire off and loads the register reset values
`default_nettype none
`include "charger_blink_fault_detector_top_defines.svh"

module charger_blink_fault_detector_top
   import cbfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // now_ms, wire_pin_level, wireless_pin_level, zeros
   input  wire logic        req_tuser,   // cmd
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // power_mode, wire_state, zeros
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg;
   item_type   req_item;
   item_type   s1_item_ff;
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_advance;
   logic       req_fire;
   logic       s1_is_query;
   result_type core_result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   cbfd_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // unpack the incoming item
   assign req_item.cmd                = req_tuser;
   assign req_item.now_ms             = req_tdata[31:0];
   assign req_item.wire_pin_level     = req_tdata[32];
   assign req_item.wireless_pin_level = req_tdata[33];

   assign s1_is_query = s1_item_ff.cmd == CMD_QUERY;

   // an edge item always moves on; a query needs room in the result register
   assign s1_advance = s1_valid_ff && (!s1_is_query || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // state update and result evaluation for the item leaving the input register
   cbfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (s1_advance),
      .item      (s1_item_ff),
      .cfg       (cfg),
      .result    (core_result)
   );

   always_comb begin
      if (s1_advance && s1_is_query) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (s1_advance && s1_is_query) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff.wire_state, rsp_data_ff.power_mode};

   // a result only ever follows a query leaving the input register
   `CBFD_ASSERT_NOW(a_rsp_from_query, $rose(rsp_valid_ff),
      $past(s1_advance && s1_is_query), "result without a query")

   // a held item in the input register is not overwritten
   `CBFD_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s1_advance,
      s1_valid_ff && $stable(s1_item_ff), "input register lost a stalled item")

   // a fault mode always comes with a fault wire state
   `CBFD_ASSERT_NOW(a_fault_consistent,
      rsp_valid_ff && (rsp_data_ff.power_mode == MODE_WIRE_FAULT),
      rsp_data_ff.wire_state == WIRE_FAULT, "fault mode without fault state")

endmodule

`default_nettype wire

[rtl/core/cbfd_regs.sv]
// apb register file holding the blink window, count and hold time
// depends on cbfd_pkg
`default_nettype none

module cbfd_regs
   import cbfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MIN_PERIOD: cfg_in.min_period_ms = csr_pwdata[15:0];
            REG_MAX_PERIOD: cfg_in.max_period_ms = csr_pwdata[15:0];
            REG_COUNT:      cfg_in.count_needed  = csr_pwdata[7:0];
            REG_HOLD:       cfg_in.hold_ms       = csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_PERIOD: csr_prdata = {16'd0, cfg_ff.min_period_ms};
         REG_MAX_PERIOD: csr_prdata = {16'd0, cfg_ff.max_period_ms};
         REG_COUNT:      csr_prdata = {24'd0, cfg_ff.count_needed};
         REG_HOLD:       csr_prdata = {16'd0, cfg_ff.hold_ms};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_period_ms <= MIN_PERIOD_RESET;
         cfg_ff.max_period_ms <= MAX_PERIOD_RESET;
         cfg_ff.count_needed  <= COUNT_RESET;
         cfg_ff.hold_ms       <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/cbfd_core.sv]
// blink detection state and query evaluation, one item per cycle
// depends on cbfd_pkg
`default_nettype none

module cbfd_core
   import cbfd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     item_fire,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result
);

   logic            parity_ff, parity_in;
   logic [31:0]     first_ff, first_in;
   logic [31:0]     last_ff, last_in;
   logic [7:0]      count_ff, count_in;
   wire_status_type status_ff, status_in;

   logic [31:0] period;
   logic [31:0] age;
   logic        in_window;
   logic        hold_fault;
   logic [7:0]  count_inc;

   // modular differences against stored edge times
   assign period     = item.now_ms - first_ff;
   assign age        = item.now_ms - last_ff;
   assign in_window  = (period > {16'd0, cfg.min_period_ms})
                     && (period < {16'd0, cfg.max_period_ms});
   assign hold_fault = (status_ff == WIRE_FAULT) && (age < {16'd0, cfg.hold_ms});
   assign count_inc  = count_ff + 8'd1;

   always_comb begin
      parity_in = parity_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      status_in = status_ff;
      if (item_fire) begin
         if (item.cmd == CMD_EDGE) begin
            last_in = item.now_ms;
            if (status_ff != WIRE_FAULT) begin
               if (!parity_ff) begin
                  first_in  = item.now_ms;
                  parity_in = 1'b1;
               end else begin
                  parity_in = 1'b0;
                  if (in_window) begin
                     count_in = count_inc;
                     if (count_inc == cfg.count_needed) begin
                        status_in = WIRE_FAULT;
                        count_in  = 8'd0;
                     end
                  end
               end
            end
         end else if (item.wireless_pin_level && !hold_fault) begin
            // pin low means the wire charger is charging
            status_in = item.wire_pin_level ? WIRE_OFF : WIRE_ON;
         end
      end
   end

   always_comb begin
      result.wire_state = status_in;
      if (!item.wireless_pin_level) begin
         result.power_mode = MODE_WIRELESS_ON;
      end else begin
         case (status_in)
            WIRE_ON:    result.power_mode = MODE_WIRE_ON;
            WIRE_FAULT: result.power_mode = MODE_WIRE_FAULT;
            default:    result.power_mode = MODE_OFF;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
         last_ff   <= 32'd0;
         count_ff  <= 8'd0;
         status_ff <= WIRE_OFF;
      end else begin
         parity_ff <= parity_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   // first edge time is always written before it is read
   always_ff @(posedge clock) begin
      first_ff <= first_in;
   end

endmodule

`default_nettype wire
